[rtl/cfmh_pkg.sv]
package cfmh_pkg;

  localparam logic [31:0] SeedReset = 32'h3141_5926;
  localparam logic [31:0] MixMul    = 32'h5bd1_e995;
  localparam int unsigned MixShift  = 24;
  localparam int unsigned AvShiftA  = 13;
  localparam int unsigned AvShiftB  = 15;

  localparam logic [7:0] AsciiUpperA = 8'h41;
  localparam logic [7:0] AsciiUpperZ = 8'h5a;
  localparam logic [7:0] AsciiCaseOffset = 8'h20;

  // configuration register indexes
  localparam logic CfgIdxSeed = 1'b0;
  localparam logic CfgIdxFold = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_K1,
    ST_K2,
    ST_H,
    ST_MIX,
    ST_FIN,
    ST_TAIL,
    ST_AV
  } state_e;

  typedef struct packed {
    logic        en;
    logic [31:0] operand;
  } mul_req_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic fold_en);
    logic [7:0] r;
    r = b;
    if (fold_en && (b >= AsciiUpperA) && (b <= AsciiUpperZ)) begin
      r = b + AsciiCaseOffset;
    end
    return r;
  endfunction

endpackage

[rtl/case_folding_murmur2_hash_unit.sv]
// Streaming MurmurHash2 (32-bit) with optional ASCII case folding.
// Input stream: one message byte per request. s_axis_tdata carries the byte and
// the total message length (sampled on the first request of a message),
// s_axis_tuser flags a real byte, s_axis_tlast closes the message. A request
// with tuser and tlast both low is a bubble and is dropped; tuser low with
// tlast high ends the message (alone, it hashes an empty message).
// Output stream: one 32-bit hash per message on m_axis_tdata.
// Configuration: cfg_we_i writes the seed (index 0) or the fold enable
// (index 1); write only while no message is in flight.
// Flow: a byte that does not complete a 32-bit word is taken without a stall;
// a byte that completes a word holds s_axis_tready low while the word mix runs
// three multiplies through the one shared constant multiplier. The last request
// passes FIN, TAIL (with leftover bytes) and AV for the tail and avalanche
// before the hash is loaded into the output register; s_axis_tready is low
// meanwhile. Reset clears the sequencer and the output valid flag and restores
// seed 0x31415926 with folding on. If the receiver stalls, a finished hash
// waits in the output register; the next holds the sequencer until it frees.
module case_folding_murmur2_hash_unit
  import cfmh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [7:0] data_byte, [39:8] msg_length
  input  logic        s_axis_tuser,   // [0] byte_valid
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] hash_value
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_wdata_i
);

  logic [31:0] seed_q;
  logic        fold_q;
  logic        out_valid_q;
  logic [31:0] out_hash_q;

  logic        res_valid;
  logic        res_ready;
  logic [31:0] res_hash;
  mul_req_t    mul_req;
  logic [31:0] mul_prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= SeedReset;
      fold_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgIdxSeed: seed_q <= cfg_wdata_i;
        CfgIdxFold: fold_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  cfmh_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seed_i      (seed_q),
    .fold_i      (fold_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata[7:0]),
    .in_bvalid_i (s_axis_tuser),
    .in_last_i   (s_axis_tlast),
    .in_len_i    (s_axis_tdata[39:8]),
    .res_ready_i (res_ready),
    .res_valid_o (res_valid),
    .res_hash_o  (res_hash),
    .mul_req_o   (mul_req),
    .mul_prod_i  (mul_prod)
  );

  cfmh_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .prod_o (mul_prod)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_hash_q <= res_hash;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_hash_q;

endmodule

[rtl/cfmh_mul.sv]
module cfmh_mul
  import cfmh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  mul_req_t    req_i,
  output logic [31:0] prod_o
);

  logic [31:0] prod_q;
  logic [31:0] prod_d;

  // low 32 bits of operand times the mixing constant
  assign prod_d = req_i.operand * MixMul;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
    end else if (req_i.en) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

[rtl/cfmh_seq.sv]
module cfmh_seq
  import cfmh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] seed_i,
  input  logic        fold_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        in_bvalid_i,
  input  logic        in_last_i,
  input  logic [31:0] in_len_i,
  input  logic        res_ready_i,
  output logic        res_valid_o,
  output logic [31:0] res_hash_o,
  output mul_req_t    mul_req_o,
  input  logic [31:0] mul_prod_i
);

  state_e      state_q, state_d;
  logic [31:0] h_q, h_d;
  logic [31:0] k_q, k_d;
  logic [23:0] buf_q, buf_d;
  logic [1:0]  phase_q, phase_d;
  logic        last_q, last_d;
  logic        in_msg_q, in_msg_d;

  logic        accept;
  logic        bubble;
  logic [23:0] base_buf;
  logic [1:0]  base_phase;
  logic [7:0]  folded;
  logic        word_full;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign bubble     = !in_bvalid_i && !in_last_i;
  // a new message starts from an empty partial word
  assign base_buf   = in_msg_q ? buf_q : '0;
  assign base_phase = in_msg_q ? phase_q : '0;
  assign folded     = fold_byte(in_byte_i, fold_i);
  assign word_full  = in_bvalid_i && (base_phase == 2'd3);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && !bubble) begin
          if (word_full) begin
            state_d = ST_K1;
          end else if (in_last_i) begin
            state_d = ST_FIN;
          end
        end
      end
      ST_K1:   state_d = ST_K2;
      ST_K2:   state_d = ST_H;
      ST_H:    state_d = ST_MIX;
      ST_MIX:  state_d = last_q ? ST_FIN : ST_IDLE;
      ST_FIN:  state_d = (phase_q != 2'd0) ? ST_TAIL : ST_AV;
      ST_TAIL: state_d = ST_AV;
      ST_AV:   state_d = res_ready_i ? ST_IDLE : ST_AV;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    h_d         = h_q;
    k_d         = k_q;
    buf_d       = buf_q;
    phase_d     = phase_q;
    last_d      = last_q;
    in_msg_d    = in_msg_q;
    mul_req_o   = '{en: 1'b0, operand: h_q};
    res_valid_o = 1'b0;
    res_hash_o  = mul_prod_i ^ (mul_prod_i >> AvShiftB);
    unique case (state_q)
      ST_IDLE: begin
        if (accept && !bubble) begin
          h_d      = in_msg_q ? h_q : (seed_i ^ in_len_i);
          last_d   = in_last_i;
          in_msg_d = !in_last_i;
          buf_d    = base_buf;
          phase_d  = base_phase;
          if (word_full) begin
            k_d     = {folded, base_buf};
            buf_d   = '0;
            phase_d = '0;
          end else if (in_bvalid_i) begin
            buf_d   = base_buf | ({16'b0, folded} << {base_phase, 3'b000});
            phase_d = base_phase + 2'd1;
          end
        end
      end
      ST_K1: begin
        mul_req_o = '{en: 1'b1, operand: k_q};
      end
      ST_K2: begin
        mul_req_o = '{en: 1'b1, operand: mul_prod_i ^ (mul_prod_i >> MixShift)};
      end
      ST_H: begin
        k_d       = mul_prod_i;
        mul_req_o = '{en: 1'b1, operand: h_q};
      end
      ST_MIX: begin
        h_d = mul_prod_i ^ k_q;
      end
      ST_FIN: begin
        // leftover bytes fold into the hash before the avalanche
        if (phase_q != 2'd0) begin
          mul_req_o = '{en: 1'b1, operand: h_q ^ {8'b0, buf_q}};
        end else begin
          mul_req_o = '{en: 1'b1, operand: h_q ^ (h_q >> AvShiftA)};
        end
      end
      ST_TAIL: begin
        mul_req_o = '{en: 1'b1, operand: mul_prod_i ^ (mul_prod_i >> AvShiftA)};
      end
      ST_AV: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          buf_d   = '0;
          phase_d = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      h_q      <= '0;
      k_q      <= '0;
      buf_q    <= '0;
      phase_q  <= '0;
      last_q   <= 1'b0;
      in_msg_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      h_q      <= h_d;
      k_q      <= k_d;
      buf_q    <= buf_d;
      phase_q  <= phase_d;
      last_q   <= last_d;
      in_msg_q <= in_msg_d;
    end
  end

endmodule

[rtl/cfmh_checker.sv]
module cfmh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // a stalled hash stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled hash changed or dropped");

  // a bubble does not make the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser && !s_axis_tlast |=> s_axis_tready)
    else $error("bubble request made the block busy");

  // the closing request always starts the finalize sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("ready right after the last request");

  // a new hash only comes out of the finalize sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("hash appeared without a finalize step");

endmodule

bind case_folding_murmur2_hash_unit cfmh_checker u_cfmh_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[tb/sv/cfmh_hash_checker.sv]
`timescale 1ns / 1ps
module cfmh_hash_checker
  import cfmh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [7:0] data_byte, [39:8] msg_length
  input  logic        s_axis_tuser,   // [0] byte_valid
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,   // [31:0] hash_value
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  output int          err_cnt_o,
  output int          pending_o
);

  logic [31:0] seed_q;
  logic        fold_q;
  logic [31:0] run_hash;
  logic [23:0] part_word;
  int          part_bytes;
  bit          msg_open;
  logic [31:0] expected_hashes[$];

  function automatic logic [31:0] mix_word(input logic [31:0] h, input logic [31:0] k);
    logic [31:0] m;
    m = k * MixMul;
    m = m ^ (m >> MixShift);
    m = m * MixMul;
    return (h * MixMul) ^ m;
  endfunction

  task automatic absorb_request(input logic [7:0] b, input bit v, input bit l,
                                input logic [31:0] len);
    logic [7:0]  fb;
    logic [31:0] h;
    // request with neither a byte nor an end is dropped
    if (!v && !l) return;
    if (!msg_open) begin
      run_hash   = seed_q ^ len;
      part_word  = '0;
      part_bytes = 0;
      msg_open   = 1'b1;
    end
    if (v) begin
      fb = (fold_q && b >= AsciiUpperA && b <= AsciiUpperZ) ? b + AsciiCaseOffset : b;
      if (part_bytes == 3) begin
        run_hash   = mix_word(run_hash, {fb, part_word});
        part_word  = '0;
        part_bytes = 0;
      end else begin
        part_word[8*part_bytes +: 8] = fb;
        part_bytes++;
      end
    end
    if (l) begin
      h = run_hash;
      if (part_bytes != 0) begin
        h = (h ^ {8'h00, part_word}) * MixMul;
      end
      h = h ^ (h >> AvShiftA);
      h = h * MixMul;
      h = h ^ (h >> AvShiftB);
      expected_hashes.push_back(h);
      run_hash   = h;
      part_word  = '0;
      part_bytes = 0;
      msg_open   = 1'b0;
    end
  endtask

  task automatic note_failure(input string what, input logic [31:0] exp_v,
                              input logic [31:0] got_v);
    if (err_cnt_o < 10) begin
      $display("%0t: %s: expected %h, got %h", $realtime, what, exp_v, got_v);
    end
    err_cnt_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q     = SeedReset;
      fold_q     = 1'b1;
      run_hash   = '0;
      part_word  = '0;
      part_bytes = 0;
      msg_open   = 1'b0;
      pending_o <= expected_hashes.size();
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CfgIdxSeed) begin
          seed_q = cfg_wdata_i;
        end else begin
          fold_q = cfg_wdata_i[0];
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_hashes.size() == 0) begin
          note_failure("hash with no message pending", '0, m_axis_tdata);
        end else if (m_axis_tdata !== expected_hashes[0]) begin
          note_failure("hash mismatch", expected_hashes[0], m_axis_tdata);
          void'(expected_hashes.pop_front());
        end else begin
          void'(expected_hashes.pop_front());
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        absorb_request(s_axis_tdata[7:0], s_axis_tuser, s_axis_tlast, s_axis_tdata[39:8]);
      end
      pending_o <= expected_hashes.size();
    end
  end

  initial begin
    err_cnt_o = 0;
  end

endmodule

[tb/sv/tb_case_folding_murmur2_hash_unit.sv]
`timescale 1ns / 1ps
module tb_case_folding_murmur2_hash_unit;
  import cfmh_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ItemsPerPhase = 320;
  localparam int unsigned HoldCycles = 300;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // [7:0] data_byte, [39:8] msg_length
  logic        s_axis_tuser;   // [0] byte_valid
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [31:0] hash_value
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [31:0] cfg_wdata_i;

  int          err_cnt;
  int          pending_cnt;
  int unsigned cycle_cnt;
  int unsigned byte_req_cnt;
  bit          idle_en;
  bit          hold_req;
  bit          hold_done;

  case_folding_murmur2_hash_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  cfmh_hash_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .err_cnt_o     (err_cnt),
    .pending_o     (pending_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Some tests failed");
    $finish;
  end

  // receiver side: random stalls, one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    hold_done = 1'b0;
    forever begin
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_done = 1'b1;
      end else if (!idle_en) begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end else if ($urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  task automatic send_req(input logic [7:0] b, input bit v, input bit l,
                          input logic [31:0] len);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {len, b};
    s_axis_tuser  <= v;
    s_axis_tlast  <= l;
    do @(posedge clk_i); while (!s_axis_tready);
    if (v || l) byte_req_cnt++;
  endtask

  task automatic write_config(input logic [31:0] seed, input logic fold);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CfgIdxSeed;
    cfg_wdata_i <= seed;
    @(posedge clk_i);
    cfg_index_i <= CfgIdxFold;
    cfg_wdata_i <= {31'b0, fold};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // let every pending hash come out, then give the sequencer time to settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic send_random_message();
    int          kind;
    int          n;
    bit          early_end;
    logic [31:0] len;
    logic [7:0]  b;
    kind = $urandom_range(0, 99);
    if (kind < 3) begin
      send_req(8'($urandom), 1'b0, 1'b0, $urandom);
      return;
    end
    if (kind < 8) begin
      send_req(8'($urandom), 1'b0, 1'b1, $urandom_range(0, 1) ? 32'd0 : 32'($urandom));
      return;
    end
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    len = ($urandom_range(0, 9) == 0) ? 32'($urandom) : 32'(n);
    early_end = ($urandom_range(0, 9) == 0);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) send_req(8'($urandom), 1'b0, 1'b0, $urandom);
      // bias toward the letters and their neighbors
      b = $urandom_range(0, 1) ? 8'($urandom_range(8'h3f, 8'h5c)) : 8'($urandom);
      send_req(b, 1'b1, (i == n - 1) && !early_end, (i == 0) ? len : 32'($urandom));
    end
    if (early_end) send_req(8'($urandom), 1'b0, 1'b1, $urandom);
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned stop_at;
    stop_at = byte_req_cnt + count;
    while (byte_req_cnt < stop_at) send_random_message();
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CfgIdxSeed;
    cfg_wdata_i   = '0;
    idle_en       = 1'b1;
    hold_req      = 1'b0;
    byte_req_cnt  = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: bubble while idle, empty messages at both length extremes
    send_req(8'hff, 1'b0, 1'b0, 32'hffff_ffff);
    send_req(8'h5a, 1'b0, 1'b1, 32'h0);
    send_req(8'h00, 1'b0, 1'b1, 32'hffff_ffff);
    // letter boundaries, byte extremes, a bubble mid-message, two full words
    send_req("A", 1'b1, 1'b0, 32'd8);
    send_req("Z", 1'b1, 1'b0, $urandom);
    send_req("@", 1'b1, 1'b0, $urandom);
    send_req(8'h00, 1'b0, 1'b0, $urandom);
    send_req("[", 1'b1, 1'b0, $urandom);
    send_req("a", 1'b1, 1'b0, $urandom);
    send_req("z", 1'b1, 1'b0, $urandom);
    send_req(8'h00, 1'b1, 1'b0, $urandom);
    send_req(8'hff, 1'b1, 1'b1, $urandom);
    // single tail byte
    send_req(8'h80, 1'b1, 1'b1, 32'd1);
    // three tail bytes under a wrong length
    send_req("Q", 1'b1, 1'b0, 32'hffff_ffff);
    send_req(8'h7f, 1'b1, 1'b0, $urandom);
    send_req("m", 1'b1, 1'b1, $urandom);
    // message closed by a request without a byte
    send_req("H", 1'b1, 1'b0, 32'd2);
    send_req("i", 1'b1, 1'b0, $urandom);
    send_req(8'hc3, 1'b0, 1'b1, $urandom);
    // exactly one word
    send_req("T", 1'b1, 1'b0, 32'd4);
    send_req("e", 1'b1, 1'b0, $urandom);
    send_req("S", 1'b1, 1'b0, $urandom);
    send_req("t", 1'b1, 1'b1, $urandom);
    drain();

    write_config(32'h0000_0000, 1'b0);
    hold_req = 1'b1;
    run_random(ItemsPerPhase);
    drain();

    write_config(32'hffff_ffff, 1'b1);
    run_random(ItemsPerPhase);
    drain();

    write_config($urandom, 1'b0);
    run_random(ItemsPerPhase);
    drain();

    write_config($urandom, 1'b1);
    idle_en = 1'b0;
    run_random(ItemsPerPhase);
    drain();

    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
